// ===== rtl/core/cata_pkg.sv =====
`timescale 1ns / 1ps

package cata_pkg;

	// reciprocal constants, q = (x * MUL) >> SHIFT is exact over the value range
	localparam int unsigned DAY_HI_DIV   = 675;
	localparam int unsigned DAY_HI_MUL   = 25451659;
	localparam int unsigned DAY_HI_SHIFT = 34;
	localparam int unsigned DAY_HI_MUL_W = 25;
	localparam int unsigned DAY_LO_BITS  = 7;

	localparam int unsigned HOUR_SECS  = 3600;
	localparam int unsigned HOUR_MUL   = 149131;
	localparam int unsigned HOUR_SHIFT = 29;
	localparam int unsigned HOUR_MUL_W = 18;

	localparam int unsigned MIN_SECS  = 60;
	localparam int unsigned MIN_MUL   = 2185;
	localparam int unsigned MIN_SHIFT = 17;
	localparam int unsigned MIN_MUL_W = 12;

	localparam int unsigned MLEN_SHIFT = 22;
	localparam int unsigned MLEN_MUL_W = 18;

	localparam int unsigned SUBSEC_W = 10;
	localparam int unsigned SEC_W    = 6;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 7;
	localparam int unsigned REM_W    = 17;
	localparam int unsigned REM2_W   = 12;

	localparam logic [4:0] MONTH_NORM [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [4:0] MONTH_LEAP [12] = '{
		5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0] year);
		logic [3:0] idx;
		idx = month - 4'd1;
		if (month < 4'd1 || month > 4'd12) begin
			return 5'd31;
		end
		if (year[1:0] == 2'b00) begin
			return MONTH_LEAP[idx];
		end
		return MONTH_NORM[idx];
	endfunction

	function automatic logic [MLEN_MUL_W-1:0] month_recip(input logic [4:0] len);
		case (len)
			5'd28:   return 18'd149797;
			5'd29:   return 18'd144632;
			5'd30:   return 18'd139811;
			default: return 18'd135301;
		endcase
	endfunction

endpackage

// ===== rtl/core/calendar_alarm_time_adder.sv =====
`timescale 1ns / 1ps

// channel   signals                     direction  beat
// input     in_valid, in_stall, ref_*   sink       timeout and reference time
//           timeout_ticks
// output    out_valid, out_stall,       source     alarm time
//           alarm_*
//
// Ten register stages; one beat per cycle while the output is not stalled.
// The stage count is set by the reciprocal multiplies for the day, hour, minute and
// month-length divisions, each followed by its own register.
// Reset clears the valid bits only.
// A stalled output beat freezes the whole pipeline; in_stall follows it in the same cycle.
module calendar_alarm_time_adder #(
	parameter int unsigned SUBSEC_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       timeout_ticks,
	input  logic [cata_pkg::SUBSEC_W-1:0]     ref_subsecond,
	input  logic [cata_pkg::SEC_W-1:0]        ref_second,
	input  logic [cata_pkg::MIN_W-1:0]        ref_minute,
	input  logic [cata_pkg::HOUR_W-1:0]       ref_hour,
	input  logic [cata_pkg::DAY_W-1:0]        ref_day,
	input  logic [cata_pkg::MONTH_W-1:0]      ref_month,
	input  logic [cata_pkg::YEAR_W-1:0]       ref_year,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cata_pkg::SUBSEC_W-1:0]     alarm_subsecond,
	output logic [cata_pkg::SEC_W-1:0]        alarm_second,
	output logic [cata_pkg::MIN_W-1:0]        alarm_minute,
	output logic [cata_pkg::HOUR_W-1:0]       alarm_hour,
	output logic [cata_pkg::DAY_W-1:0]        alarm_day
);
	import cata_pkg::*;

	localparam int unsigned SB  = SUBSEC_BITS;
	localparam int unsigned SW  = 32 - SB;
	localparam int unsigned XW  = SW - DAY_LO_BITS;
	localparam int unsigned QW  = XW - 9;
	localparam int unsigned DW  = ((QW > 5) ? QW : 5) + 2;
	localparam int unsigned PW1 = XW + DAY_HI_MUL_W;
	localparam int unsigned PW3 = REM_W + HOUR_MUL_W;
	localparam int unsigned PW5 = REM2_W + MIN_MUL_W;
	localparam int unsigned PW9 = DW + MLEN_MUL_W;
	localparam logic [SB-1:0] PREDIV = {SB{1'b1}};

	logic en;

	// stage 1
	logic [SB+SUBSEC_W-1:0] rsub_ext;
	logic [SW-1:0]          secs;
	logic [SB:0]            sub_sum;
	logic [SB-1:0]          sub_lo;
	logic [SB+SUBSEC_W-1:0] sub_out_ext;

	logic                 valid_s1;
	logic [PW1-1:0]       p1_s1;
	logic [XW-1:0]        x_s1;
	logic [DAY_LO_BITS-1:0] lo_s1;
	logic                 subc_s1;
	logic [SUBSEC_W-1:0]  subo_s1;
	logic [SEC_W-1:0]     sec_s1;
	logic [MIN_W-1:0]     min_s1;
	logic [HOUR_W-1:0]    hour_s1;
	logic [DAY_W-1:0]     day_s1;
	logic [4:0]           len_s1;

	assign rsub_ext    = {{SB{1'b0}}, ref_subsecond};
	assign secs        = timeout_ticks[31:SB];
	assign sub_sum     = {1'b0, PREDIV - rsub_ext[SB-1:0]} + {1'b0, timeout_ticks[SB-1:0]};
	assign sub_lo      = sub_sum[SB-1:0];
	assign sub_out_ext = {{SUBSEC_W{1'b0}}, ~sub_lo};

	// stage 2
	logic [QW-1:0]     q1;
	logic [XW-1:0]     r1_full;
	logic              valid_s2;
	logic [QW-1:0]     q_s2;
	logic [REM_W-1:0]  rem_s2;
	logic              subc_s2;
	logic [SUBSEC_W-1:0] subo_s2;
	logic [SEC_W-1:0]  sec_s2;
	logic [MIN_W-1:0]  min_s2;
	logic [HOUR_W-1:0] hour_s2;
	logic [DAY_W-1:0]  day_s2;
	logic [4:0]        len_s2;

	assign q1      = p1_s1[DAY_HI_SHIFT +: QW];
	assign r1_full = x_s1 - XW'(XW'(q1) * XW'(DAY_HI_DIV));

	// stage 3
	logic              valid_s3;
	logic [PW3-1:0]    p3_s3;
	logic [QW-1:0]     q_s3;
	logic [REM_W-1:0]  rem_s3;
	logic              subc_s3;
	logic [SUBSEC_W-1:0] subo_s3;
	logic [SEC_W-1:0]  sec_s3;
	logic [MIN_W-1:0]  min_s3;
	logic [HOUR_W-1:0] hour_s3;
	logic [DAY_W-1:0]  day_s3;
	logic [4:0]        len_s3;

	// stage 4
	logic [4:0]        h_w;
	logic              valid_s4;
	logic [4:0]        h_s4;
	logic [REM2_W-1:0] rem2_s4;
	logic [QW-1:0]     q_s4;
	logic              subc_s4;
	logic [SUBSEC_W-1:0] subo_s4;
	logic [SEC_W-1:0]  sec_s4;
	logic [MIN_W-1:0]  min_s4;
	logic [HOUR_W-1:0] hour_s4;
	logic [DAY_W-1:0]  day_s4;
	logic [4:0]        len_s4;

	assign h_w = p3_s3[HOUR_SHIFT +: 5];

	// stage 5
	logic              valid_s5;
	logic [PW5-1:0]    p5_s5;
	logic [REM2_W-1:0] rem2_s5;
	logic [4:0]        h_s5;
	logic [QW-1:0]     q_s5;
	logic              subc_s5;
	logic [SUBSEC_W-1:0] subo_s5;
	logic [SEC_W-1:0]  sec_s5;
	logic [MIN_W-1:0]  min_s5;
	logic [HOUR_W-1:0] hour_s5;
	logic [DAY_W-1:0]  day_s5;
	logic [4:0]        len_s5;

	// stage 6
	logic [5:0]        mq_w;
	logic              valid_s6;
	logic [5:0]        mq_s6;
	logic [5:0]        sr_s6;
	logic [4:0]        h_s6;
	logic [QW-1:0]     q_s6;
	logic              subc_s6;
	logic [SUBSEC_W-1:0] subo_s6;
	logic [SEC_W-1:0]  sec_s6;
	logic [MIN_W-1:0]  min_s6;
	logic [HOUR_W-1:0] hour_s6;
	logic [DAY_W-1:0]  day_s6;
	logic [4:0]        len_s6;

	assign mq_w = p5_s5[MIN_SHIFT +: 6];

	// stage 7
	logic [7:0]        s_sum;
	logic [1:0]        cs_w;
	logic [7:0]        m_sum;
	logic [1:0]        cm_w;
	logic              valid_s7;
	logic [SEC_W-1:0]  seco_s7;
	logic [MIN_W-1:0]  mino_s7;
	logic [1:0]        cm_s7;
	logic [4:0]        h_s7;
	logic [QW-1:0]     q_s7;
	logic [SUBSEC_W-1:0] subo_s7;
	logic [HOUR_W-1:0] hour_s7;
	logic [DAY_W-1:0]  day_s7;
	logic [4:0]        len_s7;

	assign s_sum = 8'(sec_s6) + 8'(sr_s6) + 8'(subc_s6);
	assign cs_w  = (s_sum >= 8'd120) ? 2'd2 : (s_sum >= 8'd60) ? 2'd1 : 2'd0;
	assign m_sum = 8'(min_s6) + 8'(mq_s6) + 8'(cs_w);
	assign cm_w  = (m_sum >= 8'd120) ? 2'd2 : (m_sum >= 8'd60) ? 2'd1 : 2'd0;

	// stage 8
	logic [6:0]        h_sum;
	logic [1:0]        ch_w;
	logic              valid_s8;
	logic [SEC_W-1:0]  seco_s8;
	logic [MIN_W-1:0]  mino_s8;
	logic [HOUR_W-1:0] houro_s8;
	logic [DW-1:0]     days_s8;
	logic [SUBSEC_W-1:0] subo_s8;
	logic [4:0]        len_s8;

	assign h_sum = 7'(hour_s7) + 7'(h_s7) + 7'(cm_s7);
	assign ch_w  = (h_sum >= 7'd48) ? 2'd2 : (h_sum >= 7'd24) ? 2'd1 : 2'd0;

	// stage 9
	logic              valid_s9;
	logic [PW9-1:0]    p9_s9;
	logic [DW-1:0]     days_s9;
	logic [SEC_W-1:0]  seco_s9;
	logic [MIN_W-1:0]  mino_s9;
	logic [HOUR_W-1:0] houro_s9;
	logic [SUBSEC_W-1:0] subo_s9;
	logic [4:0]        len_s9;

	// stage 10
	logic [DW-5:0]     dq_w;
	logic [DW-1:0]     dr_w;
	logic              valid_s10;
	logic [SUBSEC_W-1:0] subo_s10;
	logic [SEC_W-1:0]  seco_s10;
	logic [MIN_W-1:0]  mino_s10;
	logic [HOUR_W-1:0] houro_s10;
	logic [DAY_W-1:0]  dayo_s10;

	assign dq_w = p9_s9[MLEN_SHIFT +: DW-4];
	assign dr_w = days_s9 - DW'(DW'(dq_w) * DW'(len_s9));

	assign en       = !(valid_s10 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// split seconds into day count and remainder
			p1_s1   <= PW1'(secs[SW-1:DAY_LO_BITS]) * PW1'(DAY_HI_MUL);
			x_s1    <= secs[SW-1:DAY_LO_BITS];
			lo_s1   <= secs[DAY_LO_BITS-1:0];
			subc_s1 <= sub_sum[SB];
			subo_s1 <= sub_out_ext[SUBSEC_W-1:0];
			sec_s1  <= ref_second;
			min_s1  <= ref_minute;
			hour_s1 <= ref_hour;
			day_s1  <= ref_day;
			len_s1  <= month_len(ref_month, ref_year);

			q_s2    <= q1;
			rem_s2  <= {r1_full[9:0], lo_s1};
			subc_s2 <= subc_s1;
			subo_s2 <= subo_s1;
			sec_s2  <= sec_s1;
			min_s2  <= min_s1;
			hour_s2 <= hour_s1;
			day_s2  <= day_s1;
			len_s2  <= len_s1;

			p3_s3   <= PW3'(rem_s2) * PW3'(HOUR_MUL);
			q_s3    <= q_s2;
			rem_s3  <= rem_s2;
			subc_s3 <= subc_s2;
			subo_s3 <= subo_s2;
			sec_s3  <= sec_s2;
			min_s3  <= min_s2;
			hour_s3 <= hour_s2;
			day_s3  <= day_s2;
			len_s3  <= len_s2;

			h_s4    <= h_w;
			rem2_s4 <= REM2_W'(rem_s3 - REM_W'(REM_W'(h_w) * REM_W'(HOUR_SECS)));
			q_s4    <= q_s3;
			subc_s4 <= subc_s3;
			subo_s4 <= subo_s3;
			sec_s4  <= sec_s3;
			min_s4  <= min_s3;
			hour_s4 <= hour_s3;
			day_s4  <= day_s3;
			len_s4  <= len_s3;

			p5_s5   <= PW5'(rem2_s4) * PW5'(MIN_MUL);
			rem2_s5 <= rem2_s4;
			h_s5    <= h_s4;
			q_s5    <= q_s4;
			subc_s5 <= subc_s4;
			subo_s5 <= subo_s4;
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			hour_s5 <= hour_s4;
			day_s5  <= day_s4;
			len_s5  <= len_s4;

			mq_s6   <= mq_w;
			sr_s6   <= 6'(rem2_s5 - REM2_W'(REM2_W'(mq_w) * REM2_W'(MIN_SECS)));
			h_s6    <= h_s5;
			q_s6    <= q_s5;
			subc_s6 <= subc_s5;
			subo_s6 <= subo_s5;
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hour_s6 <= hour_s5;
			day_s6  <= day_s5;
			len_s6  <= len_s5;

			// ripple carries through seconds and minutes
			seco_s7 <= SEC_W'(s_sum - ((cs_w == 2'd2) ? 8'd120 : (cs_w == 2'd1) ? 8'd60 : 8'd0));
			mino_s7 <= MIN_W'(m_sum - ((cm_w == 2'd2) ? 8'd120 : (cm_w == 2'd1) ? 8'd60 : 8'd0));
			cm_s7   <= cm_w;
			h_s7    <= h_s6;
			q_s7    <= q_s6;
			subo_s7 <= subo_s6;
			hour_s7 <= hour_s6;
			day_s7  <= day_s6;
			len_s7  <= len_s6;

			seco_s8  <= seco_s7;
			mino_s8  <= mino_s7;
			houro_s8 <= HOUR_W'(h_sum - ((ch_w == 2'd2) ? 7'd48 : (ch_w == 2'd1) ? 7'd24 : 7'd0));
			days_s8  <= DW'(day_s7) + DW'(q_s7) + DW'(ch_w);
			subo_s8  <= subo_s7;
			len_s8   <= len_s7;

			p9_s9    <= PW9'(days_s8) * PW9'(month_recip(len_s8));
			days_s9  <= days_s8;
			seco_s9  <= seco_s8;
			mino_s9  <= mino_s8;
			houro_s9 <= houro_s8;
			subo_s9  <= subo_s8;
			len_s9   <= len_s8;

			// reduce day past month length
			subo_s10  <= subo_s9;
			seco_s10  <= seco_s9;
			mino_s10  <= mino_s9;
			houro_s10 <= houro_s9;
			dayo_s10  <= (days_s9 > DW'(len_s9)) ? dr_w[DAY_W-1:0] : days_s9[DAY_W-1:0];
		end
	end

	assign out_valid       = valid_s10;
	assign alarm_subsecond = subo_s10;
	assign alarm_second    = seco_s10;
	assign alarm_minute    = mino_s10;
	assign alarm_hour      = houro_s10;
	assign alarm_day       = dayo_s10;

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted beat did not enter stage 1");

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm_second < 6'd60)
		else $error("alarm second out of range");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm_minute < 6'd60)
		else $error("alarm minute out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm_hour < 5'd24)
		else $error("alarm hour out of range");

	a_hold_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(valid_s5) && $stable(q_s5))
		else $error("pipeline advanced while stalled");

endmodule

// ===== bench/calendar_alarm_time_adder_tb.sv =====
`timescale 1ns / 1ps

module calendar_alarm_time_adder_tb;

	localparam int unsigned SUBSEC_BITS = 10;

	typedef struct {
		logic [31:0]                      timeout;
		logic [cata_pkg::SUBSEC_W-1:0]    subsec;
		logic [cata_pkg::SEC_W-1:0]       sec;
		logic [cata_pkg::MIN_W-1:0]       min;
		logic [cata_pkg::HOUR_W-1:0]      hour;
		logic [cata_pkg::DAY_W-1:0]       day;
		logic [cata_pkg::MONTH_W-1:0]     month;
		logic [cata_pkg::YEAR_W-1:0]      year;
	} ref_time_t;

	typedef struct {
		logic [cata_pkg::SUBSEC_W-1:0]    subsec;
		logic [cata_pkg::SEC_W-1:0]       sec;
		logic [cata_pkg::MIN_W-1:0]       min;
		logic [cata_pkg::HOUR_W-1:0]      hour;
		logic [cata_pkg::DAY_W-1:0]       day;
	} alarm_time_t;

	function automatic int unsigned days_in_month(input int unsigned month,
		input int unsigned year);
		if (month < 1 || month > 12) begin
			return 31;
		end
		case (month)
			2: begin
				return ((year & 3) == 0) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	class alarm_scoreboard;
		alarm_time_t pending_alarms[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function alarm_time_t alarm_from_timeout(input ref_time_t t);
			longint unsigned prediv, secs, sub, days, rem, hours, minutes, seconds, mlen;
			alarm_time_t a;
			prediv = (64'd1 << SUBSEC_BITS) - 1;
			secs = longint'(t.timeout) >> SUBSEC_BITS;
			sub = (prediv - (longint'(t.subsec) & prediv)) + (longint'(t.timeout) & prediv);
			days = longint'(t.day) + secs / 86400;
			rem = secs % 86400;
			hours = longint'(t.hour) + rem / 3600;
			rem = rem % 3600;
			minutes = longint'(t.min) + rem / 60;
			seconds = longint'(t.sec) + rem % 60;
			seconds += sub / (prediv + 1);
			sub = sub % (prediv + 1);
			minutes += seconds / 60;
			seconds = seconds % 60;
			hours += minutes / 60;
			minutes = minutes % 60;
			days += hours / 24;
			hours = hours % 24;
			mlen = days_in_month(t.month, t.year);
			if (days > mlen) begin
				days = days % mlen;
			end
			a.subsec = 10'(prediv - sub);
			a.sec = 6'(seconds);
			a.min = 6'(minutes);
			a.hour = 5'(hours);
			a.day = 5'(days);
			return a;
		endfunction

		function void note_input(input ref_time_t t);
			pending_alarms.push_back(alarm_from_timeout(t));
		endfunction

		function void compare_field(input string name, input int unsigned want,
			input int unsigned got);
			if (want != got) begin
				$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input alarm_time_t got);
			alarm_time_t want;
			if (pending_alarms.size() == 0) begin
				$display("%0t unexpected alarm beat: expected none, actual %0d %0d:%0d:%0d.%0d",
					$time, got.day, got.hour, got.min, got.sec, got.subsec);
				mismatches++;
				return;
			end
			want = pending_alarms.pop_front();
			compare_field("alarm_subsecond", want.subsec, got.subsec);
			compare_field("alarm_second", want.sec, got.sec);
			compare_field("alarm_minute", want.min, got.min);
			compare_field("alarm_hour", want.hour, got.hour);
			compare_field("alarm_day", want.day, got.day);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] timeout_ticks;
	logic [cata_pkg::SUBSEC_W-1:0] ref_subsecond;
	logic [cata_pkg::SEC_W-1:0] ref_second;
	logic [cata_pkg::MIN_W-1:0] ref_minute;
	logic [cata_pkg::HOUR_W-1:0] ref_hour;
	logic [cata_pkg::DAY_W-1:0] ref_day;
	logic [cata_pkg::MONTH_W-1:0] ref_month;
	logic [cata_pkg::YEAR_W-1:0] ref_year;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [cata_pkg::SUBSEC_W-1:0] alarm_subsecond;
	logic [cata_pkg::SEC_W-1:0] alarm_second;
	logic [cata_pkg::MIN_W-1:0] alarm_minute;
	logic [cata_pkg::HOUR_W-1:0] alarm_hour;
	logic [cata_pkg::DAY_W-1:0] alarm_day;

	bit no_idle = 1'b0;
	alarm_scoreboard sb;

	calendar_alarm_time_adder #(
		.SUBSEC_BITS(SUBSEC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.timeout_ticks(timeout_ticks),
		.ref_subsecond(ref_subsecond),
		.ref_second(ref_second),
		.ref_minute(ref_minute),
		.ref_hour(ref_hour),
		.ref_day(ref_day),
		.ref_month(ref_month),
		.ref_year(ref_year),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.alarm_subsecond(alarm_subsecond),
		.alarm_second(alarm_second),
		.alarm_minute(alarm_minute),
		.alarm_hour(alarm_hour),
		.alarm_day(alarm_day)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(alarm_time_t'{alarm_subsecond, alarm_second, alarm_minute,
				alarm_hour, alarm_day});
		end
	end

	function automatic ref_time_t ref_time(input logic [31:0] timeout, input int unsigned subsec,
		input int unsigned sec, input int unsigned min, input int unsigned hour,
		input int unsigned day, input int unsigned month, input int unsigned year);
		ref_time_t t;
		t.timeout = timeout;
		t.subsec = 10'(subsec);
		t.sec = 6'(sec);
		t.min = 6'(min);
		t.hour = 5'(hour);
		t.day = 5'(day);
		t.month = 4'(month);
		t.year = 7'(year);
		return t;
	endfunction

	function automatic ref_time_t random_ref_time();
		ref_time_t t;
		if ($urandom_range(99) < 30) begin
			t = ref_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			t.month = 4'($urandom_range(12, 1));
			t.year = 7'($urandom_range(99));
			t.day = 5'($urandom_range(days_in_month(t.month, t.year), 1));
			t.hour = 5'($urandom_range(23));
			t.min = 6'($urandom_range(59));
			t.sec = 6'($urandom_range(59));
			t.subsec = 10'($urandom);
			case ($urandom_range(3))
				0: begin
					t.timeout = $urandom;
				end
				1: begin
					t.timeout = 32'($urandom_range(32'h0010_0000));
				end
				2: begin
					t.timeout = 32'(($urandom_range(172800) << 10) | $urandom_range(1023));
				end
				default: begin
					t.timeout = {22'($urandom_range(4194303)), 10'($urandom)};
				end
			endcase
		end
		return t;
	endfunction

	task automatic send_ref_time(input ref_time_t t);
		while (!no_idle && $urandom_range(99) < 38) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		timeout_ticks <= t.timeout;
		ref_subsecond <= t.subsec;
		ref_second <= t.sec;
		ref_minute <= t.min;
		ref_hour <= t.hour;
		ref_day <= t.day;
		ref_month <= t.month;
		ref_year <= t.year;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_input(t);
	endtask

	task automatic wait_all_alarms();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_alarms.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		timeout_ticks = '0;
		ref_subsecond = '0;
		ref_second = '0;
		ref_minute = '0;
		ref_hour = '0;
		ref_day = '0;
		ref_month = '0;
		ref_year = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_ref_time(ref_time(32'd0, 0, 0, 0, 0, 1, 1, 0));
		send_ref_time(ref_time(32'hffff_ffff, 1023, 59, 59, 23, 31, 12, 99));
		send_ref_time(ref_time(32'hffff_ffff, 1023, 63, 63, 31, 31, 15, 127));
		send_ref_time(ref_time(32'h0001_0000, 0, 30, 30, 12, 15, 0, 1));
		send_ref_time(ref_time(32'd0, 1023, 0, 0, 0, 0, 5, 3));
		send_ref_time(ref_time(32'd1, 1023, 10, 10, 10, 10, 7, 8));
		send_ref_time(ref_time(32'd1023, 0, 10, 10, 10, 10, 7, 8));
		send_ref_time(ref_time(32'h0000_03ff, 1, 0, 0, 0, 1, 1, 0));
		send_ref_time(ref_time(32'd0, 512, 63, 0, 0, 10, 3, 2));
		send_ref_time(ref_time(32'd0, 512, 0, 63, 31, 10, 3, 2));
		send_ref_time(ref_time(32'd2565734400, 1023, 0, 0, 0, 27, 2, 1));
		send_ref_time(ref_time(32'd88473600, 1023, 0, 0, 0, 29, 2, 4));
		send_ref_time(ref_time(32'd88473600, 1023, 0, 0, 0, 29, 2, 5));
		send_ref_time(ref_time(32'd88473600, 1023, 0, 0, 0, 30, 4, 7));
		send_ref_time(ref_time(32'd1, 0, 59, 59, 23, 31, 12, 99));
		send_ref_time(ref_time(32'h8000_0000, 0, 0, 0, 0, 1, 13, 127));
		send_ref_time(ref_time(32'h5555_5555, 341, 42, 21, 10, 21, 10, 42));
		send_ref_time(ref_time(32'haaaa_aaaa, 682, 21, 42, 21, 10, 5, 85));
		send_ref_time(ref_time(32'd88473600, 1023, 0, 0, 0, 31, 1, 0));
		send_ref_time(ref_time(32'd176947200, 1023, 0, 0, 0, 30, 6, 0));
		wait_all_alarms();

		for (int i = 0; i < 1900; i++) begin
			no_idle = (i >= 700 && i < 1000);
			if (i == 1300) begin
				wait_all_alarms();
			end
			send_ref_time(random_ref_time());
		end
		no_idle = 1'b0;

		wait_all_alarms();
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_alarms.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== calendar_alarm_time_adder.f =====
rtl/core/cata_pkg.sv
rtl/core/calendar_alarm_time_adder.sv
bench/calendar_alarm_time_adder_tb.sv
